@@ rtl/bmi_pkg.sv @@
package bmi_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned DefWidth = 64;
  localparam int unsigned PcW      = 4;

  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_HALVE_U,
    OP_SUB_U,
    OP_SUB_V,
    OP_HALVE_V
  } op_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_M_EVEN,
    C_M_ONE,
    C_U_ZERO,
    C_U_EVEN,
    C_V_EVEN,
    C_V_EQ_ONE,
    C_V_LT_U,
    C_V_EQ_U
  } cond_e;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_OK,
    FIN_FAIL
  } fin_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // One control word: when cond holds, run op and jump to tgt, else go to nxt.
  typedef struct packed {
    cond_e cond;
    op_e   op;
    pc_t   tgt;
    pc_t   nxt;
    fin_e  fin;
  } ucode_t;

  typedef struct packed {
    logic  load;
    op_e   op;
  } ctrl_t;

  typedef struct packed {
    logic m_even;
    logic m_one;
    logic u_zero;
    logic u_even;
    logic v_even;
    logic v_eq_one;
    logic v_lt_u;
    logic v_eq_u;
  } flags_t;

  localparam pc_t StepChkEven  = pc_t'(0);
  localparam pc_t StepChkOne   = pc_t'(1);
  localparam pc_t StepChkZero  = pc_t'(2);
  localparam pc_t StepOddU     = pc_t'(3);
  localparam pc_t StepLoopTop  = pc_t'(4);
  localparam pc_t StepSubU     = pc_t'(5);
  localparam pc_t StepHalveU   = pc_t'(6);
  localparam pc_t StepChkEqual = pc_t'(7);
  localparam pc_t StepSubV     = pc_t'(8);
  localparam pc_t StepHalveV   = pc_t'(9);
  localparam pc_t StepFail     = pc_t'(10);
  localparam pc_t StepOk       = pc_t'(11);

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      StepChkEven:  w = '{C_M_EVEN,   OP_NONE,    StepFail,    StepChkOne,   FIN_NONE};
      StepChkOne:   w = '{C_M_ONE,    OP_NONE,    StepOk,      StepChkZero,  FIN_NONE};
      StepChkZero:  w = '{C_U_ZERO,   OP_NONE,    StepFail,    StepOddU,     FIN_NONE};
      StepOddU:     w = '{C_U_EVEN,   OP_HALVE_U, StepOddU,    StepLoopTop,  FIN_NONE};
      StepLoopTop:  w = '{C_V_EQ_ONE, OP_NONE,    StepOk,      StepSubU,     FIN_NONE};
      StepSubU:     w = '{C_V_LT_U,   OP_SUB_U,   StepHalveU,  StepChkEqual, FIN_NONE};
      StepHalveU:   w = '{C_U_EVEN,   OP_HALVE_U, StepHalveU,  StepSubU,     FIN_NONE};
      StepChkEqual: w = '{C_V_EQ_U,   OP_NONE,    StepFail,    StepSubV,     FIN_NONE};
      StepSubV:     w = '{C_ALWAYS,   OP_SUB_V,   StepHalveV,  StepHalveV,   FIN_NONE};
      StepHalveV:   w = '{C_V_EVEN,   OP_HALVE_V, StepHalveV,  StepLoopTop,  FIN_NONE};
      StepOk:       w = '{C_ALWAYS,   OP_NONE,    StepOk,      StepOk,       FIN_OK};
      default:      w = '{C_ALWAYS,   OP_NONE,    StepFail,    StepFail,     FIN_FAIL};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/bmi_if.sv @@
interface bmi_in_if;
  import bmi_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] value;
  logic [DataW-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink (input valid, input value, input modulus, output ready);
endinterface

interface bmi_out_if;
  import bmi_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] inverse;
  logic             no_inverse;

  modport source (output valid, output inverse, output no_inverse, input ready);
  modport sink (input valid, input inverse, input no_inverse, output ready);
endinterface

@@ rtl/bmi_dpath.sv @@
module bmi_dpath #(
  parameter int unsigned WIDTH = bmi_pkg::DefWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bmi_pkg::ctrl_t             ctrl_i,
  input  logic [bmi_pkg::DataW-1:0]  value_i,
  input  logic [bmi_pkg::DataW-1:0]  modulus_i,
  output bmi_pkg::flags_t            flags_o,
  output logic [WIDTH-1:0]           x_o
);
  import bmi_pkg::*;

  logic [WIDTH-1:0] u_q, u_d, v_q, v_d, d_q, d_d, x_q, x_d, m_q, m_d;

  // (p + q) mod m, p and q already reduced
  function automatic logic [WIDTH-1:0] mod_add(input logic [WIDTH-1:0] p,
                                               input logic [WIDTH-1:0] q,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    s = {1'b0, p} + {1'b0, q};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WIDTH-1:0];
  endfunction

  // p / 2 mod m for odd m: add m to an odd p before the shift
  function automatic logic [WIDTH-1:0] mod_half(input logic [WIDTH-1:0] p,
                                                input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    s = {1'b0, p} + (p[0] ? {1'b0, m} : {(WIDTH+1){1'b0}});
    return s[WIDTH:1];
  endfunction

  always_comb begin
    u_d = u_q;
    v_d = v_q;
    d_d = d_q;
    x_d = x_q;
    m_d = m_q;
    if (ctrl_i.load) begin
      u_d = value_i[WIDTH-1:0];
      m_d = modulus_i[WIDTH-1:0];
      v_d = modulus_i[WIDTH-1:0];
      d_d = modulus_i[WIDTH-1:0] - WIDTH'(1);
      x_d = '0;
    end else begin
      unique case (ctrl_i.op)
        OP_HALVE_U: begin
          u_d = u_q >> 1;
          d_d = mod_half(d_q, m_q);
        end
        OP_SUB_U: begin
          u_d = u_q - v_q;
          d_d = mod_add(d_q, x_q, m_q);
        end
        OP_SUB_V: begin
          v_d = v_q - u_q;
          x_d = mod_add(x_q, d_q, m_q);
        end
        OP_HALVE_V: begin
          v_d = v_q >> 1;
          x_d = mod_half(x_q, m_q);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    v_q <= v_d;
    d_q <= d_d;
    x_q <= x_d;
    m_q <= m_d;
  end

  always_comb begin
    flags_o.m_even   = ~m_q[0];
    flags_o.m_one    = (m_q == WIDTH'(1));
    flags_o.u_zero   = (u_q == '0);
    flags_o.u_even   = ~u_q[0];
    flags_o.v_even   = ~v_q[0];
    flags_o.v_eq_one = (v_q == WIDTH'(1));
    flags_o.v_lt_u   = (v_q < u_q);
    flags_o.v_eq_u   = (v_q == u_q);
  end

  assign x_o = x_q;

  // Cofactors stay reduced whenever the loop is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctrl_i.load && ctrl_i.op != OP_NONE) |-> (d_q < m_q && x_q < m_q))
    else $error("cofactor not reduced");

  // Both remainders are odd when subtracted, so the difference is even.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctrl_i.load && (ctrl_i.op == OP_SUB_U || ctrl_i.op == OP_SUB_V))
      |-> (u_q[0] && v_q[0]))
    else $error("subtract on an even remainder");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctrl_i.load && ctrl_i.op == OP_SUB_U) |=> !u_q[0])
    else $error("remainder odd after subtract");

endmodule

@@ rtl/bmi_useq.sv @@
module bmi_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  bmi_pkg::flags_t  flags_i,
  input  logic             out_free_i,
  output bmi_pkg::ctrl_t   ctrl_o,
  output logic             busy_o,
  output logic             done_o,
  output logic             fail_o
);
  import bmi_pkg::*;

  seq_state_e state_q, state_d;
  pc_t        pc_q, pc_d;
  ucode_t     word;
  logic       cond_hit;

  assign word = ucode_rom(pc_q);

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:   cond_hit = 1'b1;
      C_M_EVEN:   cond_hit = flags_i.m_even;
      C_M_ONE:    cond_hit = flags_i.m_one;
      C_U_ZERO:   cond_hit = flags_i.u_zero;
      C_U_EVEN:   cond_hit = flags_i.u_even;
      C_V_EVEN:   cond_hit = flags_i.v_even;
      C_V_EQ_ONE: cond_hit = flags_i.v_eq_one;
      C_V_LT_U:   cond_hit = flags_i.v_lt_u;
      C_V_EQ_U:   cond_hit = flags_i.v_eq_u;
      default:    cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    ctrl_o.load = 1'b0;
    ctrl_o.op   = OP_NONE;
    done_o      = 1'b0;
    fail_o      = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          pc_d        = StepChkEven;
          state_d     = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (word.fin != FIN_NONE) begin
          // hold on the final step until the output register frees up
          if (out_free_i) begin
            done_o  = 1'b1;
            fail_o  = (word.fin == FIN_FAIL);
            state_d = SEQ_IDLE;
          end
        end else if (cond_hit) begin
          ctrl_o.op = word.op;
          pc_d      = word.tgt;
        end else begin
          pc_d = word.nxt;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pc_q    <= StepChkEven;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  assign busy_o = (state_q == SEQ_RUN);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && pc_q == StepChkEven))
    else $error("program did not start at the first step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (busy_o && (pc_q == StepOk || pc_q == StepFail || word.fin == FIN_FAIL)))
    else $error("finish outside a final step");

endmodule

@@ rtl/binary_modular_inverse_top.sv @@
// Modular inverse of a value modulo an odd modulus, binary extended Euclid.
//
// Input channel in_i carries value and modulus; output channel out_o returns
// one beat per input beat: inverse (zero-extended to 64 bits) and no_inverse.
// Only the low WIDTH bits of each input field are used. An even or zero
// modulus, a zero value, or a common factor above one raises no_inverse with
// inverse zero; modulus one gives inverse zero without the flag.
//
// One item at a time: in_i.ready is high while the sequencer is idle. The
// sequencer issues one microcode step per cycle unless it holds on the final
// step while the output register is full, and tests and branches are steps just
// as data moves are: the entry checks, each subtract, each halve and the compare
// steps between them. A subtract of u is StepSubU, its halvings and a last
// StepHalveU test; one of v is StepLoopTop, StepSubU, StepChkEqual, StepSubV,
// its halvings and a last StepHalveV test.
//
// The result sits in an output register, so the next beat is accepted while a
// result waits. If out_o.ready stays low, the next item runs to its final step
// and holds there until the output register is taken.
//
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops any
// pending result beat.
module binary_modular_inverse_top #(
  parameter int unsigned WIDTH = bmi_pkg::DefWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  bmi_in_if.sink    in_i,
  bmi_out_if.source out_o
);
  import bmi_pkg::*;

  ctrl_t            ctrl;
  flags_t           flags;
  logic             busy;
  logic             done;
  logic             fail;
  logic             start;
  logic             out_free;
  logic [WIDTH-1:0] x;

  logic             out_valid_q;
  logic [DataW-1:0] inverse_q;
  logic             no_inverse_q;

  assign in_i.ready = !busy;
  assign start      = in_i.valid && !busy;
  // output slot is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_o.ready;

  bmi_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .flags_i    (flags),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .busy_o     (busy),
    .done_o     (done),
    .fail_o     (fail)
  );

  bmi_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .value_i   (in_i.value),
    .modulus_i (in_i.modulus),
    .flags_o   (flags),
    .x_o       (x)
  );

  // Output register: load on finish, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      inverse_q    <= fail ? '0 : DataW'(x);
      no_inverse_q <= fail;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inverse    = inverse_q;
  assign out_o.no_inverse = no_inverse_q;

  // A finish never overwrites a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !done)
    else $error("result overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && no_inverse_q) |-> (inverse_q == '0))
    else $error("nonzero inverse with no_inverse set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (out_valid_q && !busy))
    else $error("finish did not present a result");

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmi_pkg::*;

  localparam int unsigned Width      = DefWidth;
  localparam int unsigned NumRandom  = 550;
  localparam int unsigned QuietLimit = 20000;
  localparam int unsigned DrainWait  = 400;
  localparam int unsigned HoldAt     = 120;
  localparam int unsigned HoldLen    = 1500;
  localparam int unsigned CalmFrom   = 300;
  localparam int unsigned CalmTo     = 380;
  localparam int unsigned IdlePct    = 31;

  typedef logic [DataW-1:0] word_t;

  typedef struct packed {
    word_t value;
    word_t modulus;
  } operand_t;

  typedef struct packed {
    word_t inverse;
    logic  no_inverse;
  } inverse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bmi_in_if  in_ch ();
  bmi_out_if out_ch ();

  binary_modular_inverse_top #(
    .WIDTH(Width)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #5 clk_i = ~clk_i;

  operand_t    operand_q[$];   // operands waiting to be offered
  inverse_t    inverse_q[$];   // predicted results, oldest first
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned quiet_cycles;

  // (p + q) mod m, with a spare carry bit so a wrap past 2^W is caught
  function automatic word_t add_mod(input word_t p, input word_t q, input word_t m);
    logic [DataW:0] s;
    s = {1'b0, p} + {1'b0, q};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[DataW-1:0];
  endfunction

  // exact halving modulo an odd m: fold in m when p is odd
  function automatic word_t half_mod(input word_t p, input word_t m);
    if (p[0]) return (p >> 1) + (m >> 1) + word_t'(1);
    return p >> 1;
  endfunction

  function automatic inverse_t predict_inverse(input operand_t op);
    word_t    mask;
    word_t    a;
    word_t    m;
    word_t    u;
    word_t    v;
    word_t    d;
    word_t    x;
    inverse_t r;
    mask = {DataW{1'b1}} >> (DataW - Width);
    a    = op.value & mask;
    m    = op.modulus & mask;
    r    = '{inverse: '0, no_inverse: 1'b0};
    if (!m[0]) begin
      r.no_inverse = 1'b1;
      return r;
    end
    if (m == word_t'(1)) return r;
    u = a % m;
    if (u == '0) begin
      r.no_inverse = 1'b1;
      return r;
    end
    v = m;
    d = m - word_t'(1);
    x = '0;
    while (!u[0]) begin
      u = u >> 1;
      d = half_mod(d, m);
    end
    while (v != word_t'(1)) begin
      while (v < u) begin
        u = u - v;
        d = add_mod(d, x, m);
        while (!u[0]) begin
          u = u >> 1;
          d = half_mod(d, m);
        end
      end
      v = v - u;
      if (v == '0) begin
        r.no_inverse = 1'b1;
        return r;
      end
      x = add_mod(x, d, m);
      while (!v[0]) begin
        v = v >> 1;
        x = half_mod(x, m);
      end
    end
    r.inverse = x & mask;
    return r;
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Build one random operand pair; most pairs are coprime with an odd modulus
  // so the full subtract/halve loop gets exercised.
  function automatic operand_t rand_operand();
    operand_t    op;
    int unsigned pick;
    word_t       k;
    pick = $urandom_range(99);
    if (pick < 60) begin
      op.modulus = rand_word() | word_t'(1);
      op.value   = rand_word();
    end else if (pick < 70) begin
      op.modulus = rand_word() & ~word_t'(1);
      op.value   = rand_word();
    end else if (pick < 80) begin
      op.modulus = (rand_word() >> $urandom_range(1, 62)) | word_t'(1);
      op.value   = rand_word() >> $urandom_range(0, 63);
    end else if (pick < 88) begin
      // shared odd factor above one
      k          = word_t'(2 * $urandom_range(1, 500) + 1);
      op.modulus = k * ((rand_word() >> 12) | word_t'(1));
      op.value   = k * (rand_word() >> 12);
    end else if (pick < 94) begin
      op.modulus = (rand_word() >> 8) | word_t'(1);
      op.value   = op.modulus * word_t'($urandom_range(0, 200));
    end else begin
      op.modulus = rand_word() | word_t'(1);
      case ($urandom_range(2))
        0:       op.value = word_t'(1);
        1:       op.value = op.modulus - word_t'(1);
        default: begin
          op.modulus = word_t'(1);
          op.value   = rand_word();
        end
      endcase
    end
    return op;
  endfunction

  // Driver: offer the next operand pair, hold it until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    operand_t op;
    if (!rst_ni) begin
      in_ch.valid   <= 1'b0;
      in_ch.value   <= '0;
      in_ch.modulus <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        inverse_q.push_back(predict_inverse('{value: in_ch.value, modulus: in_ch.modulus}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        // idle at random, except in the calm stretch
        if (operand_q.size() != 0 &&
            ((results_seen >= CalmFrom && results_seen < CalmTo) ||
             $urandom_range(99) >= IdlePct)) begin
          op = operand_q.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.value   <= op.value;
          in_ch.modulus <= op.modulus;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up, and a
  // calm stretch with ready held high.
  int unsigned hold_left;
  logic        hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HoldAt) begin
      hold_left    <= HoldLen;
      hold_done    <= 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (results_seen >= CalmFrom && results_seen < CalmTo) ||
                      ($urandom_range(99) >= IdlePct);
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    inverse_t want;
    if (!rst_ni) begin
      results_seen <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (inverse_q.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing expected: inverse %h no_inverse %b",
                 $time, out_ch.inverse, out_ch.no_inverse);
      end else begin
        want = inverse_q.pop_front();
        if (out_ch.inverse !== want.inverse) begin
          error_count++;
          $display("%0t: inverse mismatch: expected %h actual %h",
                   $time, want.inverse, out_ch.inverse);
        end
        if (out_ch.no_inverse !== want.no_inverse) begin
          error_count++;
          $display("%0t: no_inverse mismatch: expected %b actual %b",
                   $time, want.no_inverse, out_ch.no_inverse);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    word_t big_prime;
    big_prime     = 64'hFFFF_FFFF_FFFF_FFC5;

    // directed: flag cases, modulus one, extremes, long halving runs
    operand_q.push_back('{value: '0, modulus: '0});
    operand_q.push_back('{value: 64'd5, modulus: 64'd10});
    operand_q.push_back('{value: '1, modulus: 64'h8000_0000_0000_0000});
    operand_q.push_back('{value: 64'd7, modulus: 64'd1});
    operand_q.push_back('{value: '0, modulus: 64'd1});
    operand_q.push_back('{value: '1, modulus: 64'd1});
    operand_q.push_back('{value: '0, modulus: 64'd13});
    operand_q.push_back('{value: 64'd39, modulus: 64'd13});
    operand_q.push_back('{value: '1, modulus: '1});
    operand_q.push_back('{value: 64'd6, modulus: 64'd15});
    operand_q.push_back('{value: 64'd35, modulus: 64'd77});
    operand_q.push_back('{value: 64'd1, modulus: 64'd3});
    operand_q.push_back('{value: 64'd2, modulus: 64'd3});
    operand_q.push_back('{value: 64'd1, modulus: '1});
    operand_q.push_back('{value: 64'd2, modulus: '1});
    operand_q.push_back('{value: 64'hFFFF_FFFF_FFFF_FFFE, modulus: '1});
    operand_q.push_back('{value: 64'h8000_0000_0000_0000, modulus: big_prime});
    operand_q.push_back('{value: '1, modulus: big_prime});
    operand_q.push_back('{value: 64'd12345, modulus: big_prime});
    operand_q.push_back('{value: 64'd3, modulus: 64'h8000_0000_0000_0001});
    operand_q.push_back('{value: 64'hAAAA_AAAA_AAAA_AAAA, modulus: 64'h5555_5555_5555_5555});
    operand_q.push_back('{value: 64'h5555_5555_5555_5555, modulus: 64'hAAAA_AAAA_AAAA_AAAB});
    for (int unsigned i = 0; i < NumRandom; i++) operand_q.push_back(rand_operand());

    // hold reset low, then release it between clock edges
    repeat (7) @(posedge clk_i);
    #2 rst_ni = 1'b1;

    // run until every operand is taken and every prediction is met
    while ((operand_q.size() != 0 || in_ch.valid || inverse_q.size() != 0) &&
           quiet_cycles < QuietLimit)
      @(posedge clk_i);

    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: timeout with %0d results still expected", $time, inverse_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      // let any stray beat show up before the verdict
      repeat (DrainWait) @(posedge clk_i);
      if (error_count == 0 && inverse_q.size() == 0) begin
        $display("Testbench completed without errors");
      end else begin
        $display("Testbench completed WITH ERRORS");
      end
      $finish;
    end
  end

endmodule
